// ===== rtl/sps_pkg.sv =====
// Shared types, constants and helper functions for the scale pitch speller.
// Used by the table builder, the search cell and the top level; no dependencies.
package sps_pkg;

  localparam int NOTE_COUNT  = 33;
  localparam int FRAC_BITS   = 8;
  localparam int FREQ_W      = 21;
  localparam int IDX_W       = 6;
  localparam int LETTER_W    = 3;
  localparam int RATIO_W     = 17;
  localparam int RATIO_SHIFT = 16;
  localparam int KEY_COUNT   = 7;
  localparam int KEY_SEL_W   = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - LETTER_W;
  localparam int IN_PAD_W    = IN_TDATA_W - FREQ_W;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam logic [RATIO_W-1:0] SEMI_RATIO = RATIO_W'(69433);

  localparam freq_t KEY_BASE [KEY_COUNT] = '{
    freq_t'(((23308 << FRAC_BITS) + 50) / 100),
    freq_t'(((24694 << FRAC_BITS) + 50) / 100),
    freq_t'(((26163 << FRAC_BITS) + 50) / 100),
    freq_t'(((29366 << FRAC_BITS) + 50) / 100),
    freq_t'(((31113 << FRAC_BITS) + 50) / 100),
    freq_t'(((34923 << FRAC_BITS) + 50) / 100),
    freq_t'(((39200 << FRAC_BITS) + 50) / 100)
  };

  localparam logic [KEY_SEL_W-1:0] KEY_SEL_MAX = KEY_SEL_W'(KEY_COUNT - 1);

  localparam logic [LETTER_W-1:0] LETTER_C = 3'd0;
  localparam logic [LETTER_W-1:0] LETTER_D = 3'd1;
  localparam logic [LETTER_W-1:0] LETTER_E = 3'd2;
  localparam logic [LETTER_W-1:0] LETTER_F = 3'd3;
  localparam logic [LETTER_W-1:0] LETTER_G = 3'd4;
  localparam logic [LETTER_W-1:0] LETTER_A = 3'd5;
  localparam logic [LETTER_W-1:0] LETTER_B = 3'd6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FUNDAMENTAL = 2'd0,
    REG_PITCH_MODEL = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BLD_START,
    BLD_STEP,
    BLD_IDLE
  } bld_state_t;

  typedef struct packed {
    logic  push;
    freq_t value;
  } push_t;

  typedef struct packed {
    logic  valid;
    logic  rest;
    freq_t freq;
    idx_t  pos;
    idx_t  idx;
    freq_t diff;
  } token_t;

  function automatic logic is_whole_step(input idx_t i);
    return i[2:0] inside {3'd1, 3'd2, 3'd4, 3'd5};
  endfunction

  function automatic logic [LETTER_W-1:0] letter_of(input logic [2:0] p);
    logic [LETTER_W-1:0] l;
    case (p)
      3'd0:    l = LETTER_D;
      3'd1:    l = LETTER_E;
      3'd2:    l = LETTER_F;
      3'd3:    l = LETTER_G;
      3'd4:    l = LETTER_A;
      3'd5:    l = LETTER_B;
      default: l = LETTER_C;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/scale_pitch_speller.sv =====
// Nearest-note pitch quantizer: a row of search cells, each holding one scale
// table entry, refines a word that walks one cell per cycle unless a stalled
// output holds the chain. One word is in the chain at a time: a new input is
// taken only after the last result is loaded into the output register.
// Reset is synchronous; after reset and after each write to the fundamental or
// pitch model register the table is rebuilt, during which s_tready stays low.
module scale_pitch_speller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sps_pkg::IN_TDATA_W-1:0]     s_tdata,   // [20:0] frequency
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sps_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [5:0] note_index, [8:6] note_letter
  output logic                               m_tuser,   // [0] is_rest
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sps_pkg::push_t                  push;
  logic                            bld_busy;
  sps_pkg::freq_t                  entry [sps_pkg::NOTE_COUNT];
  sps_pkg::freq_t                  entry_feed [sps_pkg::NOTE_COUNT];
  sps_pkg::token_t                 tok [sps_pkg::NOTE_COUNT+1];
  sps_pkg::token_t                 head;
  sps_pkg::freq_t                  freq_in;
  logic                            accept;
  logic                            busy;
  logic                            load_out;
  logic                            advance;
  sps_pkg::token_t                 tail;
  sps_pkg::idx_t                   out_idx;
  logic [sps_pkg::LETTER_W-1:0]    out_letter;
  logic                            out_rest;

  sps_table_builder u_builder (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .busy      (bld_busy)
  );

  assign freq_in  = s_tdata[sps_pkg::FREQ_W-1:0];
  assign s_tready = !bld_busy && !busy;
  assign accept   = s_tvalid && s_tready;
  assign tail     = tok[sps_pkg::NOTE_COUNT];
  assign load_out = tail.valid && (!m_tvalid || m_tready);
  assign advance  = !tail.valid || load_out;

  always_comb begin
    head       = '0;
    head.valid = accept;
    head.freq  = freq_in;
    head.rest  = (freq_in < entry[0]) || (freq_in > entry[sps_pkg::NOTE_COUNT-1]);
  end

  assign tok[0] = head;

  for (genvar k = 0; k < sps_pkg::NOTE_COUNT; k++) begin : g_cell
    if (k == sps_pkg::NOTE_COUNT - 1) begin : g_end
      assign entry_feed[k] = push.value;
    end else begin : g_mid
      assign entry_feed[k] = entry[k+1];
    end
    sps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (push.push),
      .entry_in (entry_feed[k]),
      .entry    (entry[k]),
      .advance  (advance),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load_out) begin
        busy <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rest   <= tail.rest;
      out_idx    <= tail.rest ? '0 : tail.idx;
      out_letter <= tail.rest ? '0 : sps_pkg::letter_of(tail.idx[2:0]);
    end
  end

  assign m_tdata = {{sps_pkg::OUT_PAD_W{1'b0}}, out_letter, out_idx};
  assign m_tuser = out_rest;

endmodule

// ===== rtl/sps_cell.sv =====
// One cell of the search chain: holds one scale table entry and refines the
// passing nearest-note word against it. Depends on sps_pkg.
module sps_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  sps_pkg::freq_t  entry_in,
  output sps_pkg::freq_t  entry,
  input  logic            advance,
  input  sps_pkg::token_t tok_in,
  output sps_pkg::token_t tok_out
);

  sps_pkg::token_t tok_next;
  sps_pkg::freq_t  gap;

  always_comb begin
    gap = (tok_in.freq >= entry) ? tok_in.freq - entry : entry - tok_in.freq;
    tok_next     = tok_in;
    tok_next.pos = tok_in.pos + sps_pkg::idx_t'(1);
    if (tok_in.valid && !tok_in.rest &&
        (tok_in.pos == '0 || gap < tok_in.diff)) begin
      tok_next.idx  = tok_in.pos;
      tok_next.diff = gap;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/sps_table_builder.sv =====
// Configuration registers and the sequencer that computes the scale table one
// entry per push, with a combinational semitone multiplier. Depends on sps_pkg.
module sps_table_builder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output sps_pkg::push_t                     push,
  output logic                               busy
);

  localparam int PROD_W = sps_pkg::FREQ_W + sps_pkg::RATIO_W;
  localparam int SHR_W  = PROD_W - sps_pkg::RATIO_SHIFT;

  sps_pkg::bld_state_t              state, state_next;
  sps_pkg::freq_t                   cur, cur_next;
  sps_pkg::idx_t                    step, step_next;
  logic                             half, half_next;
  logic [sps_pkg::KEY_SEL_W-1:0]    fund_sel;
  logic                             pitch_model;
  logic                             cfg_hit;
  logic [sps_pkg::KEY_SEL_W-1:0]    key;
  sps_pkg::freq_t                   base;
  logic [PROD_W-1:0]                prod;
  logic [SHR_W-1:0]                 shr;
  sps_pkg::freq_t                   semi;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == sps_pkg::REG_FUNDAMENTAL ||
                                   cfg_index == sps_pkg::REG_PITCH_MODEL);
  assign busy      = (state != sps_pkg::BLD_IDLE);

  always_comb begin
    key  = (fund_sel > sps_pkg::KEY_SEL_MAX) ? sps_pkg::KEY_SEL_MAX : fund_sel;
    base = sps_pkg::KEY_BASE[key];
    if (!pitch_model) begin
      base = base >> 1;
    end
    prod = {{sps_pkg::RATIO_W{1'b0}}, cur} * {{sps_pkg::FREQ_W{1'b0}}, sps_pkg::SEMI_RATIO};
    shr  = prod[PROD_W-1:sps_pkg::RATIO_SHIFT];
    semi = (|shr[SHR_W-1:sps_pkg::FREQ_W]) ? '1 : shr[sps_pkg::FREQ_W-1:0];
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    step_next  = step;
    half_next  = half;
    push       = '0;
    case (state)
      sps_pkg::BLD_START: begin
        push.push  = 1'b1;
        push.value = base;
        cur_next   = base;
        step_next  = sps_pkg::idx_t'(1);
        half_next  = 1'b0;
        state_next = sps_pkg::BLD_STEP;
      end
      sps_pkg::BLD_STEP: begin
        cur_next = semi;
        if (sps_pkg::is_whole_step(step) && !half) begin
          half_next = 1'b1;
        end else begin
          push.push  = 1'b1;
          push.value = semi;
          half_next  = 1'b0;
          step_next  = step + sps_pkg::idx_t'(1);
          if (step == sps_pkg::idx_t'(sps_pkg::NOTE_COUNT - 1)) begin
            state_next = sps_pkg::BLD_IDLE;
          end
        end
      end
      sps_pkg::BLD_IDLE: begin
      end
      default: begin
        state_next = sps_pkg::BLD_START;
      end
    endcase
    if (cfg_hit) begin
      state_next = sps_pkg::BLD_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sps_pkg::BLD_START;
      fund_sel    <= '0;
      pitch_model <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index == sps_pkg::REG_FUNDAMENTAL) begin
        fund_sel <= cfg_data;
      end
      if (cfg_valid && cfg_index == sps_pkg::REG_PITCH_MODEL) begin
        pitch_model <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    step <= step_next;
    half <= half_next;
  end

endmodule
